FILE: hdl/price_time_order_matcher_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the order matcher
// Concurrent assertion wrappers, with and without reset gating.
// ---------------------------------------------------------------------------
`ifndef PRICE_TIME_ORDER_MATCHER_CORE_MACROS_SVH
`define PRICE_TIME_ORDER_MATCHER_CORE_MACROS_SVH

// checked only out of reset
`define PTOM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked at every edge, reset included
`define PTOM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/ptom_pkg.sv
// ---------------------------------------------------------------------------
// ptom_pkg
// Shared types and constants of the order matcher.
// ---------------------------------------------------------------------------
package ptom_pkg;

    localparam int LIVE_ORDERS_DEF = 32;
    localparam int PRICE_LEVELS    = 65536;
    localparam int SLOT_W          = 6;     // slot index and age rank

    localparam logic [2:0] KIND_FILL      = 3'd0;
    localparam logic [2:0] KIND_ACCEPTED  = 3'd1;
    localparam logic [2:0] KIND_CANCELLED = 3'd2;
    localparam logic [2:0] KIND_MISS      = 3'd3;
    localparam logic [2:0] KIND_REJECT    = 3'd4;

    localparam logic FUNC_LIMIT  = 1'b0;
    localparam logic FUNC_CANCEL = 1'b1;
    localparam logic SIDE_BID    = 1'b0;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_TRIM,
        CMD_DROP,
        CMD_INSERT
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t           op;
        logic [SLOT_W-1:0] idx;
        logic [SLOT_W-1:0] rank;
        logic [31:0]       amt;     // trim amount or new size
        logic [31:0]       id;
        logic [15:0]       trader;
        logic [15:0]       price;
        logic              side;
    } cmd_t;

    typedef struct packed {
        logic        side;
        logic [15:0] price;
        logic [31:0] cid;
    } qry_t;

    // running result handed along the chain
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] hit_idx;
        logic [SLOT_W-1:0] hit_rank;
        logic [15:0]       hit_price;
        logic [31:0]       hit_size;
        logic [31:0]       hit_id;
        logic [15:0]       hit_trader;
        logic              cxl_hit;
        logic [SLOT_W-1:0] cxl_idx;
        logic [SLOT_W-1:0] cxl_rank;
        logic              conflict;
        logic              free_hit;
        logic [SLOT_W-1:0] free_idx;
    } cand_t;

endpackage

FILE: hdl/ptom_cell.sv
// ---------------------------------------------------------------------------
// ptom_cell
// One order slot: holds a resting order and folds itself into the scan.
// ---------------------------------------------------------------------------
module ptom_cell
    import ptom_pkg::*;
#(
    parameter int CELL_IDX = 0
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  qry_t  qry,
    input  cmd_t  cmd,
    input  cand_t cand_in,
    output cand_t cand_out
);

    localparam logic [SLOT_W-1:0] ME = SLOT_W'(CELL_IDX);

    logic              busy_reg;
    logic [SLOT_W-1:0] rank_reg;
    logic [31:0]       size_reg;
    logic [31:0]       id_reg;
    logic [15:0]       trader_reg;
    logic [15:0]       price_reg;
    logic              side_reg;
    cand_t             cand_reg;
    cand_t             cand_next;

    logic opp;
    logic crosses;
    logic better;

    assign opp     = busy_reg && (side_reg != qry.side);
    assign crosses = (qry.side == SIDE_BID) ? (price_reg <= qry.price)
                                            : (price_reg >= qry.price);
    // best price first, oldest (highest rank) within a level
    assign better = !cand_in.hit
        || ((qry.side == SIDE_BID) ? (price_reg < cand_in.hit_price)
                                   : (price_reg > cand_in.hit_price))
        || ((price_reg == cand_in.hit_price) && (rank_reg > cand_in.hit_rank));

    always_comb begin
        cand_next = cand_in;
        if (opp && crosses && better) begin
            cand_next.hit        = 1'b1;
            cand_next.hit_idx    = ME;
            cand_next.hit_rank   = rank_reg;
            cand_next.hit_price  = price_reg;
            cand_next.hit_size   = size_reg;
            cand_next.hit_id     = id_reg;
            cand_next.hit_trader = trader_reg;
        end
        if (busy_reg && (id_reg == qry.cid) && !cand_in.cxl_hit) begin
            cand_next.cxl_hit  = 1'b1;
            cand_next.cxl_idx  = ME;
            cand_next.cxl_rank = rank_reg;
        end
        if (opp && (price_reg == qry.price)) begin
            cand_next.conflict = 1'b1;
        end
        if (!busy_reg && !cand_in.free_hit) begin
            cand_next.free_hit = 1'b1;
            cand_next.free_idx = ME;
        end
    end

    // occupancy and age rank
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            rank_reg <= '0;
        end else begin
            case (cmd.op)
                CMD_INSERT: begin
                    if (cmd.idx == ME) begin
                        busy_reg <= 1'b1;
                        rank_reg <= '0;
                    end else if (busy_reg) begin
                        rank_reg <= rank_reg + 1'b1;
                    end
                end
                CMD_DROP: begin
                    if (cmd.idx == ME) begin
                        busy_reg <= 1'b0;
                    end else if (busy_reg && (rank_reg > cmd.rank)) begin
                        rank_reg <= rank_reg - 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        cand_reg <= cand_next;
        if ((cmd.op == CMD_INSERT) && (cmd.idx == ME)) begin
            size_reg   <= cmd.amt;
            id_reg     <= cmd.id;
            trader_reg <= cmd.trader;
            price_reg  <= cmd.price;
            side_reg   <= cmd.side;
        end else if ((cmd.op == CMD_TRIM) && (cmd.idx == ME)) begin
            size_reg <= size_reg - cmd.amt;
        end
    end

    assign cand_out = cand_reg;

endmodule

FILE: hdl/price_time_order_matcher_core.sv
// ---------------------------------------------------------------------------
// price_time_order_matcher_core
// Limit order book with price-time priority over a row of order slots.
// ---------------------------------------------------------------------------
// Channel   Dir  tdata                  tuser  tlast
// s_axis    in   order fields, 136 bit  func   -
// m_axis    out  result fields, 184 bit kind   final result of the item
//
// Every query is a scan down the row of LIVE_ORDERS slot cells, one cell per
// cycle, followed by a decision state that acts on the result.
// A cancel takes one scan; a limit order takes one scan per fill plus one
// for its final result.
// A stalled result register holds the sequencer in its decision state.
// Reset frees every slot at once; no clearing pass.
// ---------------------------------------------------------------------------
module price_time_order_matcher_core
    import ptom_pkg::*;
#(
    parameter int LIVE_ORDERS = LIVE_ORDERS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // side[0], limit_price[16:1], quantity[48:17], trader_tag[64:49],
    // symbol_tag[96:65], cancel_id[128:97], zero pad above
    input  logic [135:0] s_axis_tdata,
    // func[0]
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // order_id[31:0], resting_order_id[63:32], taker_trader[79:64],
    // maker_trader[95:80], symbol_out[127:96], taker_side[128],
    // exec_price[144:129], fill_quantity[176:145], zero pad above
    output logic [183:0] m_axis_tdata,
    // kind[2:0]
    output logic [2:0]   m_axis_tuser,
    output logic         m_axis_tlast
);

    localparam int CNT_W  = (LIVE_ORDERS > 1) ? $clog2(LIVE_ORDERS) : 1;
    localparam int FILL_W = $clog2(LIVE_ORDERS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [FILL_W-1:0] nfill_reg;
    logic [31:0]       next_id_reg;
    logic              func_reg;
    qry_t              qry_reg;
    logic [31:0]       rem_reg;
    logic [31:0]       oid_reg;
    logic [15:0]       trader_reg;
    logic [31:0]       sym_reg;

    logic              m_valid_reg;
    logic [2:0]        m_kind_reg;
    logic              m_last_reg;
    logic [31:0]       m_oid_reg;
    logic [31:0]       m_rid_reg;
    logic [15:0]       m_taker_reg;
    logic [15:0]       m_maker_reg;
    logic [31:0]       m_sym_reg;
    logic              m_side_reg;
    logic [15:0]       m_price_reg;
    logic [31:0]       m_qty_reg;

    cand_t chain [LIVE_ORDERS+1];
    cand_t tail;
    cmd_t  cmd;

    logic        out_free;
    logic        do_fill;
    logic        rest;
    logic        reject;
    logic [31:0] fill_qty;

    // scan row: cell i folds its slot into the running candidate
    assign chain[0] = '0;
    for (genvar i = 0; i < LIVE_ORDERS; i++) begin : g_cell
        ptom_cell #(.CELL_IDX(i)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .qry      (qry_reg),
            .cmd      (cmd),
            .cand_in  (chain[i]),
            .cand_out (chain[i+1])
        );
    end
    assign tail = chain[LIVE_ORDERS];

    assign out_free = !m_valid_reg || m_axis_tready;
    // a fill is taken while units remain, the fill cap is not reached and the scan found a crossing order
    assign do_fill  = (rem_reg != '0) && (nfill_reg < FILL_W'(LIVE_ORDERS)) && tail.hit;
    assign fill_qty = (rem_reg < tail.hit_size) ? rem_reg : tail.hit_size;
    assign rest     = rem_reg != '0;
    assign reject   = ({1'b0, qry_reg.price} >= 17'(PRICE_LEVELS)) || !tail.free_hit
                      || tail.conflict;

    // book update, taken by the cells at the edge that leaves DECIDE
    always_comb begin
        cmd        = '0;
        cmd.op     = CMD_NONE;
        cmd.id     = oid_reg;
        cmd.trader = trader_reg;
        cmd.price  = qry_reg.price;
        cmd.side   = qry_reg.side;
        if ((state_reg == ST_DECIDE) && out_free) begin
            if (func_reg == FUNC_CANCEL) begin
                if (tail.cxl_hit) begin
                    cmd.op   = CMD_DROP;
                    cmd.idx  = tail.cxl_idx;
                    cmd.rank = tail.cxl_rank;
                end
            end else if (do_fill) begin
                cmd.idx  = tail.hit_idx;
                cmd.rank = tail.hit_rank;
                cmd.amt  = rem_reg;
                cmd.op   = (rem_reg < tail.hit_size) ? CMD_TRIM : CMD_DROP;
            end else if (rest && !reject) begin
                cmd.op  = CMD_INSERT;
                cmd.idx = tail.free_idx;
                cmd.amt = rem_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            next_id_reg <= 32'd1;
            m_valid_reg <= 1'b0;
        end else begin
            // a new result loads as the old one leaves
            if ((state_reg == ST_DECIDE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        state_reg <= ST_SCAN;
                        cnt_reg   <= '0;
                        if (s_axis_tuser == FUNC_LIMIT) begin
                            next_id_reg <= next_id_reg + 32'd1;
                        end
                    end
                end
                ST_SCAN: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(LIVE_ORDERS - 1)) begin
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    if (out_free) begin
                        cnt_reg <= '0;
                        if ((func_reg == FUNC_LIMIT) && do_fill) begin
                            state_reg <= ST_SCAN;   // rescan after the update
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // item payload and result register
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_IDLE) && s_axis_tvalid) begin
            func_reg      <= s_axis_tuser;
            qry_reg.side  <= s_axis_tdata[0];
            qry_reg.price <= s_axis_tdata[16:1];
            rem_reg       <= s_axis_tdata[48:17];
            trader_reg    <= s_axis_tdata[64:49];
            sym_reg       <= s_axis_tdata[96:65];
            qry_reg.cid   <= s_axis_tdata[128:97];
            oid_reg       <= next_id_reg;
            nfill_reg     <= '0;
        end
        if ((state_reg == ST_DECIDE) && out_free) begin
            if (func_reg == FUNC_CANCEL) begin
                m_kind_reg  <= tail.cxl_hit ? KIND_CANCELLED : KIND_MISS;
                m_last_reg  <= 1'b1;
                m_oid_reg   <= qry_reg.cid;
                m_rid_reg   <= '0;
                m_taker_reg <= '0;
                m_maker_reg <= '0;
                m_sym_reg   <= '0;
                m_side_reg  <= 1'b0;
                m_price_reg <= '0;
                m_qty_reg   <= '0;
            end else begin
                m_oid_reg   <= oid_reg;
                m_taker_reg <= trader_reg;
                m_sym_reg   <= sym_reg;
                m_side_reg  <= qry_reg.side;
                m_price_reg <= qry_reg.price;
                if (do_fill) begin
                    m_kind_reg  <= KIND_FILL;
                    m_last_reg  <= 1'b0;
                    m_rid_reg   <= tail.hit_id;
                    m_maker_reg <= tail.hit_trader;
                    m_qty_reg   <= fill_qty;
                    rem_reg     <= rem_reg - fill_qty;
                    nfill_reg   <= nfill_reg + 1'b1;
                end else begin
                    m_kind_reg  <= (rest && reject) ? KIND_REJECT : KIND_ACCEPTED;
                    m_last_reg  <= 1'b1;
                    m_rid_reg   <= '0;
                    m_maker_reg <= '0;
                    m_qty_reg   <= '0;
                end
            end
        end
    end

    assign s_axis_tready = state_reg == ST_IDLE;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_kind_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tdata  = {7'd0, m_qty_reg, m_price_reg, m_side_reg, m_sym_reg,
                            m_maker_reg, m_taker_reg, m_rid_reg, m_oid_reg};

endmodule

FILE: hdl/ptom_checker.sv
// ---------------------------------------------------------------------------
// ptom_checker
// Port-level assertions on the order matcher, bound to the top level.
// ---------------------------------------------------------------------------
`include "price_time_order_matcher_core_macros.svh"

module ptom_checker
    import ptom_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [2:0] m_axis_tuser,
    input logic       m_axis_tlast
);

    `PTOM_ASSERT(a_busy_after_accept, aclk, aresetn, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken while an item is in work")
    `PTOM_ASSERT(a_last_vs_kind, aclk, aresetn, m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser != KIND_FILL)), "fill marked last or final item not marked")
    `PTOM_ASSERT(a_hold_stalled, aclk, aresetn, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tuser), "stalled result changed")
    `PTOM_ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> !m_axis_tvalid, "result valid after reset")

endmodule

bind price_time_order_matcher_core ptom_checker u_ptom_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

FILE: tb/tb_price_time_order_matcher_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_price_time_order_matcher_core
// Self-checking bench for the limit order matcher: a queue-fed driver,
// a clocked monitor and a behavioural order book that predicts every result.
// ---------------------------------------------------------------------------
module tb_price_time_order_matcher_core;
    import ptom_pkg::*;

    localparam int    SLOTS   = LIVE_ORDERS_DEF;
    localparam logic [5:0] NO_SLOT = 6'd63;

    typedef struct {
        logic        func;
        logic        side;
        logic [15:0] price;
        logic [31:0] qty;
        logic [15:0] trader;
        logic [31:0] sym;
        logic [31:0] cid;
        bit          drain;     // hold this item back until the book is quiet
    } order_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] oid;
        logic [31:0] rid;
        logic [15:0] taker;
        logic [15:0] maker;
        logic [31:0] sym;
        logic        side;
        logic [15:0] price;
        logic [31:0] qty;
        logic        last;
    } book_res_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [183:0] m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    logic         m_axis_tlast;

    price_time_order_matcher_core i_dut (.*);

    initial begin
        forever #6 aclk = ~aclk;
    end

    // --- shadow order book ---
    logic [31:0] sl_id    [SLOTS];
    logic [31:0] sl_size  [SLOTS];
    logic [15:0] sl_trader[SLOTS];
    logic [15:0] sl_price [SLOTS];
    logic [5:0]  sl_next  [SLOTS];
    logic [5:0]  lv_head  [65536];
    logic [5:0]  lv_tail  [65536];
    bit          lv_occ   [65536];
    bit          lv_side  [65536];
    logic [15:0] bid_best, ask_best;
    bit          bid_ok, ask_ok;
    logic [SLOTS-1:0] free_map;
    logic [31:0] next_id;

    order_t    order_q[$];
    book_res_t fill_q[$];      // results still owed by the block
    order_t    cur;
    int        idle_mode;      // 0 none, 1 sender, 2 receiver, 3 both
    int        errors, n_items, n_res, n_fills, n_rejects;
    logic [31:0] gen_id;       // id the next generated limit order will get

    function automatic bit busy(int s);
        return !free_map[s];
    endfunction

    function automatic void rebuild_best();
        logic [15:0] p;
        bid_ok = 0; ask_ok = 0; bid_best = '0; ask_best = '0;
        for (int s = 0; s < SLOTS; s++) begin
            if (!busy(s)) continue;
            p = sl_price[s];
            if (!lv_side[p]) begin
                if (!bid_ok || p > bid_best) begin
                    bid_best = p; bid_ok = 1;
                end
            end else begin
                if (!ask_ok || p < ask_best) begin
                    ask_best = p; ask_ok = 1;
                end
            end
        end
    endfunction

    function automatic void unlink_slot(int s);
        logic [15:0] p;
        logic [5:0]  walk, prev;
        p = sl_price[s];
        walk = lv_head[p];
        prev = NO_SLOT;
        for (int g = 0; g < SLOTS && walk < SLOTS && walk != s; g++) begin
            prev = walk;
            walk = sl_next[walk];
        end
        if (walk == s) begin
            if (prev == NO_SLOT) lv_head[p] = sl_next[s];
            else sl_next[prev] = sl_next[s];
            if (lv_tail[p] == s) lv_tail[p] = prev;
        end
        sl_next[s] = NO_SLOT;
        free_map[s] = 1'b1;
        if (lv_head[p] >= SLOTS) begin
            lv_occ[p] = 0; lv_head[p] = NO_SLOT; lv_tail[p] = NO_SLOT;
        end
        rebuild_best();
    endfunction

    function automatic void owe(logic [2:0] k, logic [31:0] oid, logic [31:0] rid,
                                logic [15:0] tk, logic [15:0] mk, logic [31:0] sy,
                                logic sd, logic [15:0] pr, logic [31:0] q, logic l);
        book_res_t r;
        r = '{k, oid, rid, tk, mk, sy, sd, pr, q, l};
        fill_q.push_back(r);
    endfunction

    // match one accepted item against the shadow book
    function automatic void match_order(order_t o);
        logic [31:0] id, rem, fill;
        logic [15:0] lvl;
        logic [5:0]  s;
        logic [2:0]  k;
        int          n;
        n = 0;
        if (o.func == FUNC_CANCEL) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (busy(i) && sl_id[i] == o.cid) begin
                    unlink_slot(i);
                    owe(KIND_CANCELLED, o.cid, 0, 0, 0, 0, 0, 0, 0, 1);
                    return;
                end
            end
            owe(KIND_MISS, o.cid, 0, 0, 0, 0, 0, 0, 0, 1);
            return;
        end
        id = next_id;
        next_id = next_id + 1;
        rem = o.qty;
        while (rem > 0 && n < SLOTS) begin
            if (o.side == SIDE_BID) begin
                if (!ask_ok || ask_best > o.price) break;
                lvl = ask_best;
            end else begin
                if (!bid_ok || bid_best < o.price) break;
                lvl = bid_best;
            end
            s = lv_head[lvl];
            if (s >= SLOTS || !busy(s)) break;
            fill = (rem < sl_size[s]) ? rem : sl_size[s];
            owe(KIND_FILL, id, sl_id[s], o.trader, sl_trader[s], o.sym, o.side,
                o.price, fill, 0);
            n++;
            if (rem < sl_size[s]) begin
                sl_size[s] = sl_size[s] - rem;
                rem = 0;
            end else begin
                rem = rem - sl_size[s];
                unlink_slot(s);
            end
        end
        k = KIND_ACCEPTED;
        if (rem > 0) begin
            // prices are 16 bit, so every price has a level
            if (free_map == '0 || (lv_occ[o.price] && lv_side[o.price] != o.side)) begin
                k = KIND_REJECT;
            end else begin
                s = 0;
                while (busy(s)) s++;
                free_map[s] = 1'b0;
                sl_id[s] = id; sl_size[s] = rem; sl_trader[s] = o.trader;
                sl_price[s] = o.price; sl_next[s] = NO_SLOT;
                if (!lv_occ[o.price] || lv_tail[o.price] >= SLOTS) begin
                    lv_occ[o.price] = 1;
                    lv_side[o.price] = o.side;
                    lv_head[o.price] = s;
                end else begin
                    sl_next[lv_tail[o.price]] = s;
                end
                lv_tail[o.price] = s;
                rebuild_best();
            end
        end
        owe(k, id, 0, o.trader, 0, o.sym, o.side, o.price, 0, 1);
    endfunction

    function automatic void add_limit(logic sd, logic [15:0] pr, logic [31:0] q,
                                      logic [15:0] tr, bit drain = 0);
        order_t o;
        o = '{FUNC_LIMIT, sd, pr, q, tr, $urandom, $urandom, drain};
        gen_id = gen_id + 1;
        order_q.push_back(o);
    endfunction

    function automatic void add_cancel(logic [31:0] id, bit drain = 0);
        order_t o;
        o = '{FUNC_CANCEL, $urandom_range(0, 1), $urandom, $urandom, $urandom,
              $urandom, id, drain};
        order_q.push_back(o);
    endfunction

    // --- driver: one nonblocking write per signal per edge ---
    always @(posedge aclk) begin
        bit offer;
        int idle_pct;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                match_order(cur);
                n_items++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                idle_pct = (idle_mode == 1) ? 86 : (idle_mode == 3) ? 38 : 0;
                offer = order_q.size() > 0 && $urandom_range(99, 0) >= idle_pct;
                if (offer && order_q[0].drain && fill_q.size() > 0) offer = 0;
                if (offer) begin
                    cur = order_q.pop_front();
                    s_axis_tdata <= {7'd0, cur.cid, cur.sym, cur.trader, cur.qty,
                                     cur.price, cur.side};
                    s_axis_tuser <= cur.func;
                end
                s_axis_tvalid <= offer;
            end
        end
    end

    // --- monitor ---
    always @(posedge aclk) begin
        book_res_t got, want;
        int stall_pct;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32],
                        m_axis_tdata[79:64], m_axis_tdata[95:80], m_axis_tdata[127:96],
                        m_axis_tdata[128], m_axis_tdata[144:129], m_axis_tdata[176:145],
                        m_axis_tlast};
                n_res++;
                if (got.kind == KIND_FILL) n_fills++;
                if (got.kind == KIND_REJECT) n_rejects++;
                if (fill_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result %p", $time, got);
                end else begin
                    want = fill_q.pop_front();
                    if (got !== want) begin
                        errors++;
                        $display("%0t: mismatch expected %p actual %p", $time, want, got);
                    end
                end
            end
            stall_pct = (idle_mode == 2) ? 86 : (idle_mode == 3) ? 38 : 0;
            m_axis_tready <= $urandom_range(99, 0) >= stall_pct;
        end
    end

    task automatic wait_quiet();
        while (order_q.size() > 0 || s_axis_tvalid || fill_q.size() > 0)
            @(posedge aclk);
    endtask

    initial begin
        logic [15:0] mid;
        int r;
        errors = 0; n_items = 0; n_res = 0; n_fills = 0; n_rejects = 0;
        idle_mode = 0;
        free_map = '1; next_id = 1; gen_id = 1;
        bid_ok = 0; ask_ok = 0; bid_best = '0; ask_best = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: misses on an empty book, crossing, extremes, zero size/price
        add_cancel(32'd5);
        add_cancel(32'hFFFF_FFFF);
        add_limit(SIDE_BID, 16'd100, 32'd10, 16'h0000);
        add_limit(1'b1, 16'd100, 32'd4, 16'hFFFF);          // partial fill
        add_limit(1'b1, 16'd90, 32'd20, 16'h1234);          // fill then rest
        add_limit(SIDE_BID, 16'hFFFF, 32'hFFFF_FFFF, 16'h00FF); // sweep, huge rest
        add_limit(SIDE_BID, 16'd50, 32'd0, 16'h0F0F);       // zero size
        add_limit(1'b1, 16'd0, 32'd3, 16'hF0F0);            // zero price
        add_limit(1'b1, 16'd0, 32'd0, 16'h0001);
        add_cancel(32'd4);                                  // the resting sweep
        add_cancel(32'd4);                                  // now gone
        add_cancel(32'd0);
        wait_quiet();

        // book full: 33 asks at one level, then one bid takes the 32 resting
        for (int i = 0; i < 33; i++) add_limit(1'b1, 16'd200, 32'd1, i[15:0]);
        add_limit(SIDE_BID, 16'd300, 32'd40, 16'hABCD);
        wait_quiet();
        for (int s = 0; s < SLOTS; s++) if (busy(s)) add_cancel(sl_id[s]);
        wait_quiet();

        // random phases, each entered with the pipe drained
        for (int ph = 0; ph < 4; ph++) begin
            idle_mode = ph;
            mid = $urandom_range(60000, 100);
            for (int i = 0; i < 60; i++) begin
                r = $urandom_range(99, 0);
                if (r < 62) begin
                    add_limit($urandom_range(0, 1), mid + $urandom_range(20, 0) - 10,
                              ($urandom_range(9, 0) == 0) ? $urandom :
                              ($urandom_range(19, 0) == 0) ? 32'd0 : $urandom_range(40, 1),
                              $urandom, i == 0);
                end else if (r < 90) begin
                    add_cancel(gen_id - $urandom_range(40, 1), i == 0);
                end else if (r < 95) begin
                    add_limit($urandom_range(0, 1), $urandom, $urandom, $urandom, i == 0);
                end else begin
                    add_cancel($urandom, i == 0);
                end
            end
            // mid-phase hold-off until the book has answered everything
            add_cancel(gen_id - 1, 1);
            for (int i = 0; i < 10; i++)
                add_limit($urandom_range(0, 1), mid + $urandom_range(6, 0) - 3,
                          $urandom_range(30, 1), $urandom);
            wait_quiet();
        end

        repeat (100) @(posedge aclk);
        $display("Covered %0d items, %0d results: %0d fills, %0d rejects.",
                 n_items, n_res, n_fills, n_rejects);
        $display("Book-full, sweep, zero size/price, cancel miss and four idle mixes.");
        if (errors == 0 && fill_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("Timeout with %0d results outstanding", fill_q.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
